FILE: src/wsd_pkg.sv
// Shared types, constants and codes for the wheel slip detector.
package wsd_pkg;

  localparam int SPEED_W      = 24;
  localparam int MAX_WIN_LOG2 = 6;
  localparam int DEPTH        = 1 << MAX_WIN_LOG2;
  localparam int IDX_W        = MAX_WIN_LOG2;
  localparam int CNT_W        = MAX_WIN_LOG2 + 1;
  localparam int SUM_W        = SPEED_W + MAX_WIN_LOG2;
  localparam int STEP_W       = $clog2(SUM_W);
  localparam int LOG2_W       = 3;
  localparam int ALLOW_W      = 17;
  localparam int FLOOR_W      = 23;
  localparam int CFG_W        = 23;
  localparam int CFG_IDX_W    = 3;
  localparam int Q_FRAC       = 16;
  localparam int ONE_Q16      = 1 << Q_FRAC;
  localparam int FACT_W       = ALLOW_W + 1;
  localparam int HI_PROD_W    = SPEED_W + FACT_W;
  localparam int LO_PROD_W    = SPEED_W + 1 + FACT_W;
  localparam int LHS_W        = SPEED_W + Q_FRAC;

  localparam logic [LOG2_W-1:0]  WIN_LOG2_RST = LOG2_W'(3);
  localparam logic [ALLOW_W-1:0] ALLOW_RST    = ALLOW_W'(6554);
  localparam logic [FLOOR_W-1:0] FLOOR_RST    = FLOOR_W'(3277);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LOG2 = 3'd0,
    CFG_ALLOWANCE   = 3'd1,
    CFG_FLOOR       = 3'd2,
    CFG_MODEL_VALID = 3'd3,
    CFG_STASIS      = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MS_CORRECT    = 2'd0,
    MS_FREE_WHEEL = 2'd1,
    MS_STASIS     = 2'd2,
    MS_SETUP_ERR  = 2'd3
  } motion_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_PREP,
    ST_DIV,
    ST_AVG,
    ST_MUL,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic signed [SPEED_W-1:0] drive_speed;
    logic signed [SPEED_W-1:0] stasis_speed;
  } wsd_in_t;

  typedef struct packed {
    logic [1:0]                motion_state;
    logic                      stasis_enabled;
    logic signed [SPEED_W-1:0] drive_speed_now;
    logic signed [SPEED_W-1:0] drive_speed_avg;
    logic signed [SPEED_W-1:0] stasis_speed_now;
    logic signed [SPEED_W-1:0] stasis_speed_avg;
  } wsd_out_t;

  typedef struct packed {
    logic accept;
    logic update;
    logic prep;
    logic div_step;
    logic avg;
    logic mul;
    logic out_load;
  } wsd_cmd_t;

  typedef struct packed {
    logic model_valid;
    logic fill_mode;
    logic div_last;
  } wsd_sts_t;

endpackage

FILE: src/wsd_ctrl.sv
// Sequencer for the wheel slip detector: handshakes and datapath commands.
module wsd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  wsd_pkg::wsd_sts_t sts_i,
  output wsd_pkg::wsd_cmd_t cmd_o
);
  import wsd_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   can_load;

  assign can_load = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.model_valid ? ST_READ : ST_DONE;
        end
      end
      ST_READ: state_d = ST_PREP;
      ST_PREP: state_d = sts_i.fill_mode ? ST_DIV : ST_AVG;
      ST_DIV: begin
        if (sts_i.div_last) begin
          state_d = ST_AVG;
        end
      end
      ST_AVG:  state_d = ST_MUL;
      ST_MUL:  state_d = ST_DONE;
      ST_DONE: begin
        if (can_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    in_ready_o     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_READ: cmd_o.update   = 1'b1;
      ST_PREP: cmd_o.prep     = 1'b1;
      ST_DIV:  cmd_o.div_step = 1'b1;
      ST_AVG:  cmd_o.avg      = 1'b1;
      ST_MUL:  cmd_o.mul      = 1'b1;
      ST_DONE: cmd_o.out_load = can_load;
      default: cmd_o          = '0;
    endcase
  end

  // Output register: set on load, drop when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    priority if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: src/wsd_datapath.sv
// Datapath: config registers, ring windows, running sums, serial divider, slip test.
module wsd_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [wsd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [wsd_pkg::CFG_W-1:0]      cfg_data_i,
  input  wsd_pkg::wsd_in_t               in_data_i,
  input  wsd_pkg::wsd_cmd_t              cmd_i,
  output wsd_pkg::wsd_sts_t              sts_o,
  output wsd_pkg::wsd_out_t              out_data_o
);
  import wsd_pkg::*;

  // configuration
  logic [LOG2_W-1:0]  log2_q;
  logic [ALLOW_W-1:0] allow_q;
  logic [FLOOR_W-1:0] floor_q;
  logic               model_valid_q;
  logic               stasis_q;
  logic               win_wr;

  // window memories
  logic signed [SPEED_W-1:0] dmem [DEPTH];
  logic signed [SPEED_W-1:0] smem [DEPTH];
  logic signed [SPEED_W-1:0] drd_q, srd_q;

  logic signed [SPEED_W-1:0] d_q, s_q;
  logic                      err_q;
  logic signed [SUM_W-1:0]   dsum_q, ssum_q, dsum_d, ssum_d;
  logic [IDX_W-1:0]          slot_q;
  logic [CNT_W-1:0]          fill_q;
  logic                      fill_mode_q;
  logic [CNT_W-1:0]          len_w;
  logic [IDX_W-1:0]          mask_w;
  logic                      fill_now;
  logic signed [SPEED_W-1:0] dold, sold;

  // divider
  logic [SUM_W-1:0]  dq_q, sq_q;
  logic [CNT_W-1:0]  drem_q, srem_q;
  logic              dneg_q, sneg_q;
  logic [STEP_W-1:0] step_q;
  logic [SUM_W-1:0]  dmag, smag;
  logic [CNT_W:0]    dpart, spart;
  logic              dge, sge;

  // averages and compare
  logic signed [SPEED_W-1:0]   davg_q, savg_q, davg_d, savg_d;
  logic signed [SPEED_W-1:0]   dquot, squot;
  logic signed [SUM_W-1:0]     dshift, sshift;
  logic [SPEED_W-1:0]          ad, as_mag;
  logic [FACT_W-1:0]           hi_fact;
  logic signed [FACT_W-1:0]    lo_fact;
  logic [HI_PROD_W-1:0]        hi_prod_q;
  logic signed [LO_PROD_W-1:0] lo_prod_q;
  logic [LHS_W-1:0]            lhs_q;
  logic                        above_q;
  logic                        free_w, stasis_w;
  wsd_out_t                    out_q, out_d;

  assign win_wr = cfg_we_i && (cfg_idx_i == CFG_WINDOW_LOG2)
                  && (cfg_data_i[LOG2_W-1:0] <= LOG2_W'(MAX_WIN_LOG2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log2_q        <= WIN_LOG2_RST;
      allow_q       <= ALLOW_RST;
      floor_q       <= FLOOR_RST;
      model_valid_q <= 1'b0;
      stasis_q      <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WINDOW_LOG2: begin
          if (win_wr) begin
            log2_q <= cfg_data_i[LOG2_W-1:0];
          end
        end
        CFG_ALLOWANCE:   allow_q       <= cfg_data_i[ALLOW_W-1:0];
        CFG_FLOOR:       floor_q       <= cfg_data_i[FLOOR_W-1:0];
        CFG_MODEL_VALID: model_valid_q <= cfg_data_i[0];
        CFG_STASIS:      stasis_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign len_w    = CNT_W'(1) << log2_q;
  assign mask_w   = IDX_W'(len_w - CNT_W'(1));
  assign fill_now = fill_q < len_w;

  // Slots not yet written since the last clear read as zero.
  assign dold   = fill_now ? '0 : drd_q;
  assign sold   = fill_now ? '0 : srd_q;
  assign dsum_d = dsum_q + SUM_W'(d_q) - SUM_W'(dold);
  assign ssum_d = ssum_q + SUM_W'(s_q) - SUM_W'(sold);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      drd_q <= dmem[slot_q];
      srd_q <= smem[slot_q];
    end
    if (cmd_i.update) begin
      dmem[slot_q] <= d_q;
      smem[slot_q] <= s_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      d_q   <= in_data_i.drive_speed;
      s_q   <= in_data_i.stasis_speed;
      err_q <= !model_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dsum_q      <= '0;
      ssum_q      <= '0;
      slot_q      <= '0;
      fill_q      <= '0;
      fill_mode_q <= 1'b0;
    end else if (win_wr) begin
      dsum_q <= '0;
      ssum_q <= '0;
      slot_q <= '0;
      fill_q <= '0;
    end else if (cmd_i.update) begin
      dsum_q      <= dsum_d;
      ssum_q      <= ssum_d;
      slot_q      <= (slot_q + IDX_W'(1)) & mask_w;
      fill_mode_q <= fill_now;
      if (fill_now) begin
        fill_q <= fill_q + CNT_W'(1);
      end
    end
  end

  // Restoring division of |sum| by the fill count, one quotient bit a cycle.
  assign dmag  = dsum_q[SUM_W-1] ? SUM_W'(-dsum_q) : SUM_W'(dsum_q);
  assign smag  = ssum_q[SUM_W-1] ? SUM_W'(-ssum_q) : SUM_W'(ssum_q);
  assign dpart = {drem_q, dq_q[SUM_W-1]};
  assign spart = {srem_q, sq_q[SUM_W-1]};
  assign dge   = dpart >= {1'b0, fill_q};
  assign sge   = spart >= {1'b0, fill_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      dq_q   <= dmag;
      sq_q   <= smag;
      drem_q <= '0;
      srem_q <= '0;
      dneg_q <= dsum_q[SUM_W-1];
      sneg_q <= ssum_q[SUM_W-1];
      step_q <= '0;
    end else if (cmd_i.div_step) begin
      dq_q   <= {dq_q[SUM_W-2:0], dge};
      sq_q   <= {sq_q[SUM_W-2:0], sge};
      drem_q <= dge ? CNT_W'(dpart - {1'b0, fill_q}) : dpart[CNT_W-1:0];
      srem_q <= sge ? CNT_W'(spart - {1'b0, fill_q}) : spart[CNT_W-1:0];
      step_q <= step_q + STEP_W'(1);
    end
  end

  assign dquot  = dq_q[SPEED_W-1:0];
  assign squot  = sq_q[SPEED_W-1:0];
  assign dshift = dsum_q >>> log2_q;
  assign sshift = ssum_q >>> log2_q;

  always_comb begin
    if (fill_mode_q) begin
      davg_d = dneg_q ? -dquot : dquot;
      savg_d = sneg_q ? -squot : squot;
    end else begin
      davg_d = dshift[SPEED_W-1:0];
      savg_d = sshift[SPEED_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.avg) begin
      davg_q <= davg_d;
      savg_q <= savg_d;
    end
  end

  assign ad      = davg_q[SPEED_W-1] ? SPEED_W'(-davg_q) : SPEED_W'(davg_q);
  assign as_mag  = savg_q[SPEED_W-1] ? SPEED_W'(-savg_q) : SPEED_W'(savg_q);
  assign hi_fact = FACT_W'(ONE_Q16) + FACT_W'(allow_q);
  assign lo_fact = FACT_W'(ONE_Q16) - FACT_W'(allow_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      hi_prod_q <= HI_PROD_W'(ad) * HI_PROD_W'(hi_fact);
      lo_prod_q <= LO_PROD_W'($signed({1'b0, ad})) * LO_PROD_W'(lo_fact);
      lhs_q     <= {as_mag, {Q_FRAC{1'b0}}};
      above_q   <= (ad > SPEED_W'(floor_q)) || (as_mag > SPEED_W'(floor_q));
    end
  end

  assign free_w   = HI_PROD_W'(lhs_q) > hi_prod_q;
  assign stasis_w = $signed(LO_PROD_W'(lhs_q)) < lo_prod_q;

  always_comb begin
    out_d = '0;
    if (err_q) begin
      out_d.motion_state = MS_SETUP_ERR;
    end else begin
      out_d.stasis_enabled   = stasis_q;
      out_d.drive_speed_now  = d_q;
      out_d.drive_speed_avg  = davg_q;
      out_d.stasis_speed_now = s_q;
      out_d.stasis_speed_avg = savg_q;
      out_d.motion_state     = MS_CORRECT;
      if (stasis_q && above_q) begin
        priority if (free_w) begin
          out_d.motion_state = MS_FREE_WHEEL;
        end else if (stasis_w) begin
          out_d.motion_state = MS_STASIS;
        end else begin
          out_d.motion_state = MS_CORRECT;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  assign out_data_o        = out_q;
  assign sts_o.model_valid = model_valid_q;
  assign sts_o.fill_mode   = fill_mode_q;
  assign sts_o.div_last    = step_q == STEP_W'(SUM_W - 1);

endmodule

FILE: src/wheel_slip_detector_unit.sv
// Top level of the wheel slip detector: sequencer plus datapath.
//
//  channel   direction  handshake                 payload
//  in        input      in_valid_i / in_ready_o   in_data_i   (wsd_in_t)
//  out       output     out_valid_o / out_ready_i out_data_o  (wsd_out_t)
//  cfg       input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One request at a time. While the window fills, the average comes from the 30-step
// serial divider for sum / count; with a full window it is the sum shifted right.
// With the model invalid an item skips the window; no window state changes.
// Reset and a window-size write up to 6 clear sums, fill count and slot index at once.
// A finished result waits in the output register while the next request is taken.
module wheel_slip_detector_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  wsd_pkg::wsd_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output wsd_pkg::wsd_out_t             out_data_o,
  input  logic                          cfg_we_i,
  input  logic [wsd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [wsd_pkg::CFG_W-1:0]     cfg_data_i
);
  import wsd_pkg::*;

  wsd_cmd_t cmd;
  wsd_sts_t sts;

  wsd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  wsd_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule
